FILE: rtl/gwf_pkg.sv
// ----------------------------------------------------------------------------
// gwf_pkg
// Shared types, codes and constants of the grid wipe fade engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gwf_pkg;

  localparam int GRID_W_DEF = 10;
  localparam int GRID_H_DEF = 120;

  localparam int IDX_W   = 11;
  localparam int CMD_W   = 2;
  localparam int SPEED_W = 14;
  localparam int AGE_W   = 11;
  localparam int ROW_W   = 8;
  localparam int COL_W   = 6;
  localparam int RAD_W   = 8;
  localparam int MARK_N  = 16;
  localparam int MAGE_W  = 13;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] REG_FADE_MODE    = 2'd0;
  localparam logic [1:0] REG_WIPE_PATTERN = 2'd1;
  localparam logic [1:0] REG_FADE_SPEED   = 2'd2;

  localparam logic [1:0] MODE_FADE_OUT = 2'd1;
  localparam logic [1:0] MODE_FADE_IN  = 2'd2;

  localparam logic [1:0] PAT_CENTRE = 2'd0;
  localparam logic [1:0] PAT_EDGES  = 2'd1;
  localparam logic [1:0] PAT_SWEEP  = 2'd2;
  localparam logic [1:0] PAT_NONE   = 2'd3;

  localparam logic [1:0] KIND_CENTRE = 2'd0;
  localparam logic [1:0] KIND_EDGES  = 2'd1;
  localparam logic [1:0] KIND_UP     = 2'd2;
  localparam logic [1:0] KIND_DOWN   = 2'd3;

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_FADE = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [1:0] DRAW_NONE   = 2'd0;
  localparam logic [1:0] DRAW_BLEND  = 2'd1;
  localparam logic [1:0] DRAW_OPAQUE = 2'd2;

  localparam logic [13:0]       AGE_LIMIT = 14'd999;
  localparam logic [AGE_W-1:0]  AGE_FULL  = 11'd1000;
  localparam logic [16:0]       DIV10_MUL = 17'd52429;
  localparam logic [15:0]       ALPHA_MUL = 16'd33555;
  localparam logic signed [7:0] ALPHA_TOP = 8'sd31;
  localparam logic signed [7:0] ALPHA_SAT = 8'sd32;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] cell_index;
  } gwf_in_t;

  typedef struct packed {
    logic       transition_done;
    logic       still_active;
    logic [1:0] draw_kind;
    logic [4:0] fade_level;
    logic [9:0] pixel_x;
    logic [8:0] pixel_y;
  } gwf_out_t;

  typedef struct packed {
    logic load;
    logic arm;
    logic clear_en;
    logic instant;
    logic mark_init;
    logic mark_en;
    logic pass_init;
    logic pass_en;
    logic rd_init;
    logic div_en;
    logic out_load;
  } gwf_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             tick_run;
    logic             tick_instant;
    logic             no_mark;
    logic             clr_last;
    logic             mark_last;
    logic             pass_last;
    logic             div_last;
  } gwf_sts_t;

endpackage

`default_nettype wire

FILE: rtl/gwf_if.sv
// ----------------------------------------------------------------------------
// gwf_if
// Valid/ready stream channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface gwf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gwf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/grid_wipe_fade_engine_core.sv
// ----------------------------------------------------------------------------
// grid_wipe_fade_engine_core
// Screen-transition wipe engine over a grid of fading cells.
//
// Commands arrive on in_i (start, tick, read one cell); each command gives
// exactly one transfer on out_o. Registers are written on cfg_i, which is
// always ready and must only be used while the engine is idle.
// One command is worked on at a time; in_i is ready again once the previous
// reply sits in the output register, so a stalled receiver only holds the
// engine when a second reply is ready before the first has been taken.
// Reply path per command, with C = GRID_W * GRID_H cells (1200 by default):
//   start: the clearing sweep of all C cells of the cell memory.
//   tick:  the wipe row marking steps (none for the NONE pattern), then the ageing
//          pass, one cell per cycle through the separate read and write ports of the cell memory.
//   read:  the two-step reciprocal split of the cell index.
//   instant or inactive tick, unknown command: straight to the reply.
// After reset the memory is cleared, and in_i is not ready during the sweep.
// The output register holds its reply until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_wipe_fade_engine_core #(
  parameter int GRID_W = gwf_pkg::GRID_W_DEF,
  parameter int GRID_H = gwf_pkg::GRID_H_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  gwf_stream_if.sink          in_i,
  gwf_stream_if.source        out_o,
  gwf_cfg_if.sink             cfg_i
);
  import gwf_pkg::*;

  gwf_cmd_t cmd;
  gwf_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  gwf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gwf_dp #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_i.payload),
    .out_data_o (out_o.payload),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign cfg_i.ready = 1'b1;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("A second command was taken while one is in progress.");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_en |-> !in_i.ready)
    else $error("Input ready during the clearing sweep.");

  a_load_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("Reply loaded over an untaken reply.");

endmodule

`default_nettype wire

FILE: rtl/gwf_ctrl.sv
// ----------------------------------------------------------------------------
// gwf_ctrl
// Sequencer of the engine: clearing, marking, ageing pass, read and reply.
// ----------------------------------------------------------------------------
`default_nettype none

module gwf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  gwf_pkg::gwf_sts_t sts_i,
  output gwf_pkg::gwf_cmd_t cmd_o
);
  import gwf_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_PASS  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.cmd)
          CMD_START: begin
            cmd_o.arm = 1'b1;
            state_d   = S_CLEAR;
          end
          CMD_TICK: begin
            if (sts_i.tick_run && sts_i.no_mark) begin
              cmd_o.mark_init = 1'b1;
              cmd_o.pass_init = 1'b1;
              state_d         = S_PASS;
            end else if (sts_i.tick_run) begin
              cmd_o.mark_init = 1'b1;
              state_d         = S_MARK;
            end else begin
              cmd_o.instant = sts_i.tick_instant;
              state_d       = S_FIN;
            end
          end
          CMD_READ: begin
            cmd_o.rd_init = 1'b1;
            state_d       = S_DIV;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clr_last) state_d = S_FIN;
      end
      S_MARK: begin
        cmd_o.mark_en = 1'b1;
        if (sts_i.mark_last) begin
          cmd_o.pass_init = 1'b1;
          state_d         = S_PASS;
        end
      end
      S_PASS: begin
        cmd_o.pass_en = 1'b1;
        if (sts_i.pass_last) state_d = S_FIN;
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/gwf_dp.sv
// ----------------------------------------------------------------------------
// gwf_dp
// Datapath: cell memory, wipe row marking, ageing pass, read decode.
// ----------------------------------------------------------------------------
`default_nettype none

module gwf_dp #(
  parameter int GRID_W = gwf_pkg::GRID_W_DEF,
  parameter int GRID_H = gwf_pkg::GRID_H_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gwf_pkg::gwf_cmd_t cmd_i,
  output gwf_pkg::gwf_sts_t sts_o,
  input  gwf_pkg::gwf_in_t  in_data_i,
  output gwf_pkg::gwf_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [13:0]       cfg_data_i
);
  import gwf_pkg::*;

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW    = $clog2(CELLS);
  localparam int HALF  = GRID_H / 2;
  localparam int MW    = 2 + AGE_W;
  localparam int RSH   = 18;
  localparam int RECIP = (2**RSH + GRID_W - 1) / GRID_W;
  localparam int PW    = IDX_W + RSH;

  logic [1:0]         mode_q, pat_q;
  logic [SPEED_W-1:0] speed_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [IDX_W-1:0]   idx_q;
  logic               armed_q, done_q, nf_q;
  logic [RAD_W-1:0]   radius_q;
  logic [AGE_W-1:0]   step_q;
  logic [30:0]        sp_mul;

  logic [AW-1:0]      addr_q;
  logic [ROW_W-1:0]   row_q, wb_row_q;
  logic [COL_W-1:0]   col_q;
  logic               iss_done_q, wb_v_q, wb_last_q;
  logic [AW-1:0]      wb_addr_q;
  logic               any_q, nfacc_q;
  logic               issue_v, addr_last;

  logic [MW-1:0]      mem [CELLS];
  logic [MW-1:0]      mem_rd_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic [MW-1:0]      mem_wd;

  logic [2:0]         k_q;
  logic [3:0]         rows_q;
  logic [1:0]         kind_q;
  logic [9:0]         per_q;
  logic [2:0]         mult;
  logic [MAGE_W-1:0]  age_k;
  logic signed [10:0] rad, ra, rb;
  logic               va, vb, grow;
  logic               ent_v   [MARK_N];
  logic [ROW_W-1:0]   ent_row [MARK_N];
  logic [MAGE_W-1:0]  ent_age [MARK_N];

  logic               hit;
  logic [MAGE_W-1:0]  hage;
  logic [1:0]         ph, new_ph;
  logic [AGE_W-1:0]   age, new_age;
  logic [13:0]        base, sum;
  logic               fade, c_any, c_nf;

  logic [PW-1:0]      rprod;
  logic [IDX_W-1:0]   rquo, rrem, rq_q;
  logic [COL_W-1:0]   col_rd_q;

  logic [26:0]        qm;
  logic signed [7:0]  qv, av;
  logic               a_set, in_range;
  logic [1:0]         kind;
  logic [4:0]         level;
  gwf_out_t           res, out_q;

  assign sp_mul = 31'(speed_q) * 31'(DIV10_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      pat_q   <= '0;
      speed_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FADE_MODE:    mode_q  <= cfg_data_i[1:0];
        REG_WIPE_PATTERN: pat_q   <= cfg_data_i[1:0];
        REG_FADE_SPEED:   speed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= sp_mul[29:19];
    if (cmd_i.load) idx_q <= in_data_i.cell_index;
  end

  // Row marking: one wipe step per cycle, up to two rows each.
  assign mult  = 3'(rows_q - 4'd1 - {1'b0, k_q});
  assign age_k = MAGE_W'(per_q * mult);
  assign rad   = {3'b000, radius_q};

  always_comb begin
    ra = rad;
    rb = rad;
    vb = 1'b0;
    unique case (kind_q)
      KIND_CENTRE: begin
        ra = 11'(HALF) - rad;
        rb = 11'(HALF) + rad;
        vb = 1'b1;
      end
      KIND_EDGES: begin
        rb = 11'(GRID_H) - rad;
        vb = 1'b1;
      end
      KIND_UP:   ra = 11'(GRID_H) - rad - 11'sd1;
      KIND_DOWN: ra = rad;
      default: ;
    endcase
    va   = !ra[10] && (ra[9:0] < 10'(GRID_H));
    vb   = vb && !rb[10] && (rb[9:0] < 10'(GRID_H));
    grow = (kind_q == KIND_CENTRE || kind_q == KIND_EDGES) ?
           (radius_q < RAD_W'(HALF)) : (radius_q < RAD_W'(GRID_H));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_init) begin
      for (int e = 0; e < MARK_N; e++) ent_v[e] <= 1'b0;
    end else if (cmd_i.mark_en) begin
      ent_v[{k_q, 1'b0}]   <= va;
      ent_row[{k_q, 1'b0}] <= ra[ROW_W-1:0];
      ent_age[{k_q, 1'b0}] <= age_k;
      ent_v[{k_q, 1'b1}]   <= vb;
      ent_row[{k_q, 1'b1}] <= rb[ROW_W-1:0];
      ent_age[{k_q, 1'b1}] <= age_k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      rows_q <= 4'd2;
      kind_q <= KIND_CENTRE;
      per_q  <= '0;
    end else if (cmd_i.mark_init) begin
      k_q <= '0;
      if (pat_q == PAT_SWEEP) begin
        kind_q <= (mode_q == MODE_FADE_OUT) ? KIND_UP : KIND_DOWN;
        rows_q <= (mode_q == MODE_FADE_OUT) ? 4'd4 : 4'd8;
        per_q  <= (mode_q == MODE_FADE_OUT) ? 10'(step_q >> 2) : 10'(step_q >> 3);
      end else begin
        kind_q <= (pat_q == PAT_CENTRE) ? KIND_CENTRE : KIND_EDGES;
        rows_q <= (mode_q == MODE_FADE_OUT) ? 4'd2 : 4'd4;
        per_q  <= (mode_q == MODE_FADE_OUT) ? 10'(step_q >> 1) : 10'(step_q >> 2);
      end
    end else if (cmd_i.mark_en) begin
      k_q <= k_q + 3'd1;
    end
  end

  // Ageing pass: read one cell per cycle, write it back in the cycle after the read.
  assign addr_last = (addr_q == AW'(CELLS - 1));
  assign issue_v   = cmd_i.pass_en && !iss_done_q;

  always_comb begin
    hit  = 1'b0;
    hage = '0;
    for (int e = MARK_N - 1; e >= 0; e--) begin
      if (ent_v[e] && ent_row[e] == wb_row_q) begin
        hit  = 1'b1;
        hage = ent_age[e];
      end
    end
  end

  assign ph  = mem_rd_q[MW-1:AGE_W];
  assign age = mem_rd_q[AGE_W-1:0];

  always_comb begin
    new_ph  = ph;
    new_age = age;
    c_any   = 1'b0;
    c_nf    = 1'b0;
    fade    = 1'b0;
    base    = {3'b000, age};
    unique case (ph)
      PH_WAIT: begin
        if (hit) begin
          base = {1'b0, hage};
          fade = 1'b1;
        end else begin
          c_any = 1'b1;
          c_nf  = 1'b1;
        end
      end
      PH_FADE: fade = 1'b1;
      default: ;
    endcase
    sum = base + {3'b000, step_q};
    if (fade) begin
      c_any = 1'b1;
      if (sum > AGE_LIMIT) begin
        new_ph  = PH_DONE;
        new_age = AGE_FULL;
      end else begin
        new_ph  = PH_FADE;
        new_age = sum[AGE_W-1:0];
        c_nf    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      row_q      <= '0;
      col_q      <= '0;
      iss_done_q <= 1'b0;
      wb_v_q     <= 1'b0;
      wb_last_q  <= 1'b0;
      any_q      <= 1'b0;
      nfacc_q    <= 1'b0;
    end else begin
      wb_v_q    <= issue_v;
      wb_last_q <= issue_v && addr_last;
      if (cmd_i.clear_en) begin
        addr_q <= addr_last ? '0 : addr_q + AW'(1);
      end else if (cmd_i.pass_init) begin
        addr_q     <= '0;
        row_q      <= '0;
        col_q      <= '0;
        iss_done_q <= 1'b0;
        any_q      <= 1'b0;
        nfacc_q    <= 1'b0;
      end else if (issue_v) begin
        if (addr_last) begin
          iss_done_q <= 1'b1;
          addr_q     <= '0;
        end else begin
          addr_q <= addr_q + AW'(1);
          if (col_q == COL_W'(GRID_W - 1)) begin
            col_q <= '0;
            row_q <= row_q + ROW_W'(1);
          end else begin
            col_q <= col_q + COL_W'(1);
          end
        end
      end
      if (wb_v_q) begin
        any_q   <= any_q | c_any;
        nfacc_q <= nfacc_q | c_nf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wb_addr_q <= addr_q;
    wb_row_q  <= row_q;
  end

  assign mem_we = cmd_i.clear_en || wb_v_q;
  assign mem_wa = cmd_i.clear_en ? addr_q : wb_addr_q;
  assign mem_wd = cmd_i.clear_en ? '0 : {new_ph, new_age};
  assign mem_re = issue_v || cmd_i.rd_init;
  assign mem_ra = cmd_i.rd_init ? AW'(idx_q) : addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_q <= mem[mem_ra];
  end

  // Engine flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= CMD_START;
      armed_q  <= 1'b0;
      done_q   <= 1'b0;
      nf_q     <= 1'b0;
      radius_q <= '0;
    end else begin
      if (cmd_i.load) cmd_q <= in_data_i.command;
      if (cmd_i.arm) begin
        armed_q  <= 1'b1;
        done_q   <= 1'b0;
        nf_q     <= 1'b1;
        radius_q <= '0;
      end
      if (cmd_i.instant) done_q <= 1'b1;
      if (cmd_i.mark_en && grow) radius_q <= radius_q + RAD_W'(1);
      if (wb_v_q && wb_last_q) begin
        done_q <= !(any_q || c_any);
        nf_q   <= nfacc_q || c_nf;
      end
    end
  end

  // Read: cell index split into row and column by reciprocal multiplication.
  assign rprod = PW'(idx_q) * PW'(RECIP);
  assign rquo  = rprod[PW-1:RSH];
  assign rrem  = idx_q - rq_q * IDX_W'(GRID_W);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_init) rq_q <= rquo;
    if (cmd_i.div_en) col_rd_q <= rrem[COL_W-1:0];
  end

  assign qm       = 27'(age) * 27'(ALPHA_MUL);
  assign qv       = {1'b0, qm[26:20]};
  assign in_range = (int'(idx_q) < CELLS);

  always_comb begin
    kind  = DRAW_NONE;
    level = '0;
    av    = '0;
    a_set = 1'b0;
    if (mode_q == MODE_FADE_IN) begin
      if (ph == PH_FADE) begin
        av    = qv;
        a_set = 1'b1;
      end else if (ph == PH_DONE) begin
        kind = DRAW_OPAQUE;
      end
    end else begin
      if (ph == PH_WAIT) begin
        kind = DRAW_OPAQUE;
      end else if (ph == PH_FADE) begin
        av    = ALPHA_TOP - qv;
        a_set = 1'b1;
      end
    end
    if (a_set && av >= ALPHA_SAT) begin
      kind = DRAW_OPAQUE;
    end else if (a_set && av > 8'sd0) begin
      kind  = DRAW_BLEND;
      level = av[4:0];
    end
    if (!armed_q) begin
      kind  = DRAW_NONE;
      level = '0;
    end
  end

  always_comb begin
    res                 = '0;
    res.transition_done = done_q;
    res.still_active    = armed_q && nf_q;
    if (cmd_q == CMD_READ && in_range) begin
      res.draw_kind  = kind;
      res.fade_level = level;
      res.pixel_x    = {col_rd_q[3:0], 6'b000000};
      res.pixel_y    = {rq_q[6:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= res;
  end

  assign out_data_o = out_q;

  assign sts_o.cmd          = cmd_q;
  assign sts_o.tick_run     = armed_q && !done_q &&
                              (mode_q == MODE_FADE_OUT || mode_q == MODE_FADE_IN);
  assign sts_o.tick_instant = armed_q && !done_q &&
                              !(mode_q == MODE_FADE_OUT || mode_q == MODE_FADE_IN);
  assign sts_o.no_mark      = (pat_q == PAT_NONE);
  assign sts_o.clr_last     = addr_last;
  assign sts_o.mark_last    = (({1'b0, k_q} + 4'd1) == rows_q);
  assign sts_o.pass_last    = wb_v_q && wb_last_q;
  assign sts_o.div_last     = 1'b1;

endmodule

`default_nettype wire
